[design/mmd_pkg.sv]
`timescale 1ns / 1ps

package mmd_pkg;

    localparam int CHANNEL_COUNT   = 5;
    localparam int DECIMATION      = 4;
    localparam int SINE_TABLE_BITS = 10;

    localparam int SAMPLE_W     = 16;
    localparam int PHASE_W      = 32;
    localparam int CH_IDX_W     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int SINE_MAG_W   = 15;
    localparam int SINE_ENTRIES = 2 ** SINE_TABLE_BITS;

    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int MIXF_W     = PROD_W + 2;
    localparam int MIX_SHIFT  = SAMPLE_W - 1;
    localparam int MIX_ROUND  = 2 ** (MIX_SHIFT - 1);
    localparam int MIX_W      = SAMPLE_W + 1;
    localparam int SUM_W      = 19;
    localparam int ACC_W      = SUM_W + 1;
    localparam int DCNT_W     = $clog2(DECIMATION);

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    localparam int OUT_MAX = 2 ** (SAMPLE_W - 1) - 1;
    localparam int OUT_MIN = -(2 ** (SAMPLE_W - 1));

    // Floor division of a biased sum by DECIMATION through an exact reciprocal.
    localparam int     DIV_IN_W   = ACC_W;
    localparam int     DIV_SHIFT  = DIV_IN_W + DCNT_W;
    localparam int     DIV_MUL_W  = DIV_IN_W + 1;
    localparam int     DIV_PROD_W = DIV_IN_W + DIV_MUL_W;
    localparam longint DIV_MUL    =
        ((longint'(1) << DIV_SHIFT) + DECIMATION - 1) / DECIMATION;
    localparam int     DIV_BIAS_Q = ((2 ** (SUM_W - 1)) + DECIMATION - 1) / DECIMATION;
    localparam int     DIV_BIAS   = DIV_BIAS_Q * DECIMATION;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SINE_MAG_W-1:0] sine_rom_t [SINE_ENTRIES];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] val;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            x    = (HALF_PI_Q30 * 64'(2 * k + 1)) >> (SINE_TABLE_BITS + 1);
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 13; n += 2) begin
                term = (term * x2) >> 30;
                term = term / 64'((n + 1) * (n + 2));
                if ((((n + 1) / 2) % 2) != 0) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            val = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
            if (val > 64'd32767) begin
                val = 64'd32767;
            end
            rom[k] = val[SINE_MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[design/mmd_sine_rom.sv]
`timescale 1ns / 1ps

module mmd_sine_rom (
    input  logic                                aclk,
    input  logic                                rd_en,
    input  logic [mmd_pkg::SINE_TABLE_BITS-1:0] addr_a,
    input  logic [mmd_pkg::SINE_TABLE_BITS-1:0] addr_b,
    output logic [mmd_pkg::SINE_MAG_W-1:0]      data_a,
    output logic [mmd_pkg::SINE_MAG_W-1:0]      data_b
);

    logic [mmd_pkg::SINE_MAG_W-1:0] data_a_reg;
    logic [mmd_pkg::SINE_MAG_W-1:0] data_b_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_a_reg <= mmd_pkg::SINE_ROM[addr_a];
            data_b_reg <= mmd_pkg::SINE_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

[design/multichannel_mix_decimate.sv]
// Results of a decimation item pass the snapshot and output buffer registers and
// leave one channel per cycle in channel order while m_ready is high.
// Throughput: one item per cycle while s_ready is high; five pipeline stages; output
// buffer drains CHANNEL_COUNT results per DECIMATION items, bounding sustained rate.
// Reset (aresetn, synchronous, active low) clears phases, steps, sums and all valids.
`timescale 1ns / 1ps

module multichannel_mix_decimate (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_write_en,
    input  logic [mmd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mmd_pkg::PHASE_W-1:0]            cfg_write_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [mmd_pkg::SAMPLE_W-1:0]    s_in_real,
    input  logic signed [mmd_pkg::SAMPLE_W-1:0]    s_in_imag,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [mmd_pkg::CH_IDX_W-1:0]           m_channel_index,
    output logic signed [mmd_pkg::SAMPLE_W-1:0]    m_out_real,
    output logic signed [mmd_pkg::SAMPLE_W-1:0]    m_out_imag,
    output logic                                   m_last_channel
);

    localparam int CH = mmd_pkg::CHANNEL_COUNT;

    logic [mmd_pkg::PHASE_W-1:0]         step_reg  [CH];
    logic [mmd_pkg::PHASE_W-1:0]         phase_reg [CH];

    logic [mmd_pkg::SINE_TABLE_BITS-1:0] sin_addr [CH];
    logic [mmd_pkg::SINE_TABLE_BITS-1:0] cos_addr [CH];
    logic [mmd_pkg::SINE_MAG_W-1:0]      sin_mag  [CH];
    logic [mmd_pkg::SINE_MAG_W-1:0]      cos_mag  [CH];
    logic                                neg_s_reg [CH];
    logic                                neg_c_reg [CH];
    logic signed [mmd_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [mmd_pkg::SAMPLE_W-1:0] y_reg;
    logic                                v1_reg;

    logic signed [mmd_pkg::SAMPLE_W-1:0] sin_val [CH];
    logic signed [mmd_pkg::SAMPLE_W-1:0] cos_val [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_xc_reg [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_ys_reg [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_xs_reg [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_yc_reg [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_xc_next [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_ys_next [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_xs_next [CH];
    logic signed [mmd_pkg::PROD_W-1:0]   p_yc_next [CH];
    logic                                v2_reg;

    logic signed [mmd_pkg::MIX_W-1:0]    mix_re_reg  [CH];
    logic signed [mmd_pkg::MIX_W-1:0]    mix_im_reg  [CH];
    logic signed [mmd_pkg::MIX_W-1:0]    mix_re_next [CH];
    logic signed [mmd_pkg::MIX_W-1:0]    mix_im_next [CH];
    logic                                v3_reg;

    logic [mmd_pkg::SUM_W-1:0]           sum_re_reg  [CH];
    logic [mmd_pkg::SUM_W-1:0]           sum_im_reg  [CH];
    logic [mmd_pkg::SUM_W-1:0]           sum_re_next [CH];
    logic [mmd_pkg::SUM_W-1:0]           sum_im_next [CH];
    logic [mmd_pkg::SUM_W-1:0]           snap_re_reg  [CH];
    logic [mmd_pkg::SUM_W-1:0]           snap_im_reg  [CH];
    logic [mmd_pkg::SUM_W-1:0]           snap_re_next [CH];
    logic [mmd_pkg::SUM_W-1:0]           snap_im_next [CH];
    logic                                snap_valid_reg;
    logic                                snap_valid_next;
    logic [mmd_pkg::DCNT_W-1:0]          dcnt_reg;
    logic [mmd_pkg::DCNT_W-1:0]          dcnt_next;

    logic [mmd_pkg::SAMPLE_W-1:0]        buf_re_reg  [CH];
    logic [mmd_pkg::SAMPLE_W-1:0]        buf_im_reg  [CH];
    logic [mmd_pkg::SAMPLE_W-1:0]        buf_re_next [CH];
    logic [mmd_pkg::SAMPLE_W-1:0]        buf_im_next [CH];
    logic [mmd_pkg::CH_IDX_W-1:0]        out_cnt_reg;
    logic [mmd_pkg::CH_IDX_W-1:0]        out_cnt_next;
    logic                                busy_reg;
    logic                                busy_next;

    logic accept;
    logic adv;
    logic dump_now;
    logic last_now;
    logic m_accept;
    logic buf_free;
    logic snap_free;
    logic load_e;

    function automatic logic [mmd_pkg::SUM_W-1:0] sat_sum(
        input logic [mmd_pkg::ACC_W-1:0] a
    );
        logic [mmd_pkg::SUM_W-1:0] r;
        if (a[mmd_pkg::ACC_W-1] != a[mmd_pkg::ACC_W-2]) begin
            r = a[mmd_pkg::ACC_W-1] ? mmd_pkg::SUM_MIN : mmd_pkg::SUM_MAX;
        end else begin
            r = a[mmd_pkg::SUM_W-1:0];
        end
        return r;
    endfunction

    // Floor of s / DECIMATION, then saturated to the sample range.
    function automatic logic [mmd_pkg::SAMPLE_W-1:0] dump_div(
        input logic signed [mmd_pkg::SUM_W-1:0] s
    );
        logic [mmd_pkg::DIV_IN_W-1:0]   u;
        logic [mmd_pkg::DIV_PROD_W-1:0] prod;
        logic signed [mmd_pkg::ACC_W-1:0] q;
        logic [mmd_pkg::SAMPLE_W-1:0]   r;
        u    = mmd_pkg::DIV_IN_W'(s) + mmd_pkg::DIV_IN_W'(mmd_pkg::DIV_BIAS);
        prod = mmd_pkg::DIV_PROD_W'(u) * mmd_pkg::DIV_PROD_W'(mmd_pkg::DIV_MUL);
        q    = $signed(mmd_pkg::ACC_W'(prod[mmd_pkg::DIV_PROD_W-1:mmd_pkg::DIV_SHIFT]))
             - mmd_pkg::ACC_W'(mmd_pkg::DIV_BIAS_Q);
        if (q > mmd_pkg::ACC_W'(mmd_pkg::OUT_MAX)) begin
            r = mmd_pkg::SAMPLE_W'(mmd_pkg::OUT_MAX);
        end else if (q < mmd_pkg::ACC_W'(mmd_pkg::OUT_MIN)) begin
            r = mmd_pkg::SAMPLE_W'(mmd_pkg::OUT_MIN);
        end else begin
            r = q[mmd_pkg::SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // Handshake and flow control. The front stages hold only when a decimation
    // item reaches the accumulators while both the snapshot and the output
    // buffer are still occupied.
    assign last_now  = (out_cnt_reg == mmd_pkg::CH_IDX_W'(CH - 1));
    assign m_accept  = busy_reg && m_ready;
    assign buf_free  = !busy_reg || (m_ready && last_now);
    assign snap_free = !snap_valid_reg || buf_free;
    assign dump_now  = (dcnt_reg == mmd_pkg::DCNT_W'(mmd_pkg::DECIMATION - 1));
    assign adv       = !(v3_reg && dump_now && !snap_free);
    assign accept    = s_valid && adv;
    assign load_e    = snap_valid_reg && buf_free;
    assign s_ready   = adv;

    assign m_valid         = busy_reg;
    assign m_channel_index = out_cnt_reg;
    assign m_out_real      = buf_re_reg[0];
    assign m_out_imag      = buf_im_reg[0];
    assign m_last_channel  = last_now;

    // Oscillator and table lookup.
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            if (phase_reg[c][mmd_pkg::PHASE_W-2]) begin
                sin_addr[c] = ~phase_reg[c][mmd_pkg::PHASE_W-3 -: mmd_pkg::SINE_TABLE_BITS];
                cos_addr[c] = phase_reg[c][mmd_pkg::PHASE_W-3 -: mmd_pkg::SINE_TABLE_BITS];
            end else begin
                sin_addr[c] = phase_reg[c][mmd_pkg::PHASE_W-3 -: mmd_pkg::SINE_TABLE_BITS];
                cos_addr[c] = ~phase_reg[c][mmd_pkg::PHASE_W-3 -: mmd_pkg::SINE_TABLE_BITS];
            end
        end
    end

    for (genvar c = 0; c < CH; c++) begin : g_rom
        mmd_sine_rom u_rom (
            .aclk   (aclk),
            .rd_en  (accept),
            .addr_a (sin_addr[c]),
            .addr_b (cos_addr[c]),
            .data_a (sin_mag[c]),
            .data_b (cos_mag[c])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CH; c++) begin
                step_reg[c]  <= '0;
                phase_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < CH; c++) begin
                if (cfg_write_en && (cfg_index == mmd_pkg::CFG_IDX_W'(c))) begin
                    step_reg[c] <= cfg_write_data;
                end
                if (accept) begin
                    phase_reg[c] <= phase_reg[c] + step_reg[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_in_real;
            y_reg <= s_in_imag;
            for (int c = 0; c < CH; c++) begin
                neg_s_reg[c] <= phase_reg[c][mmd_pkg::PHASE_W-1];
                neg_c_reg[c] <= phase_reg[c][mmd_pkg::PHASE_W-1]
                              ^ phase_reg[c][mmd_pkg::PHASE_W-2];
            end
        end
    end

    // Products.
    always_comb begin
        for (int c = 0; c < CH; c++) begin
            sin_val[c] = neg_s_reg[c] ? -$signed({1'b0, sin_mag[c]})
                                      : $signed({1'b0, sin_mag[c]});
            cos_val[c] = neg_c_reg[c] ? -$signed({1'b0, cos_mag[c]})
                                      : $signed({1'b0, cos_mag[c]});
            p_xc_next[c] = mmd_pkg::PROD_W'(x_reg) * mmd_pkg::PROD_W'(cos_val[c]);
            p_ys_next[c] = mmd_pkg::PROD_W'(y_reg) * mmd_pkg::PROD_W'(sin_val[c]);
            p_xs_next[c] = mmd_pkg::PROD_W'(x_reg) * mmd_pkg::PROD_W'(sin_val[c]);
            p_yc_next[c] = mmd_pkg::PROD_W'(y_reg) * mmd_pkg::PROD_W'(cos_val[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v1_reg) begin
            p_xc_reg <= p_xc_next;
            p_ys_reg <= p_ys_next;
            p_xs_reg <= p_xs_next;
            p_yc_reg <= p_yc_next;
        end
    end

    // Complex sum and rounding to Q2.15 (half added, then floor).
    always_comb begin
        logic signed [mmd_pkg::MIXF_W-1:0] re_full;
        logic signed [mmd_pkg::MIXF_W-1:0] im_full;
        for (int c = 0; c < CH; c++) begin
            re_full = mmd_pkg::MIXF_W'(p_xc_reg[c]) - mmd_pkg::MIXF_W'(p_ys_reg[c])
                    + mmd_pkg::MIXF_W'(mmd_pkg::MIX_ROUND);
            im_full = mmd_pkg::MIXF_W'(p_xs_reg[c]) + mmd_pkg::MIXF_W'(p_yc_reg[c])
                    + mmd_pkg::MIXF_W'(mmd_pkg::MIX_ROUND);
            mix_re_next[c] = re_full[mmd_pkg::MIX_SHIFT + mmd_pkg::MIX_W - 1:mmd_pkg::MIX_SHIFT];
            mix_im_next[c] = im_full[mmd_pkg::MIX_SHIFT + mmd_pkg::MIX_W - 1:mmd_pkg::MIX_SHIFT];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v2_reg) begin
            mix_re_reg <= mix_re_next;
            mix_im_reg <= mix_im_next;
        end
    end

    // Accumulate with saturation; on the last item of a block, snapshot and clear.
    always_comb begin
        logic [mmd_pkg::SUM_W-1:0] sat_re;
        logic [mmd_pkg::SUM_W-1:0] sat_im;
        for (int c = 0; c < CH; c++) begin
            sat_re = sat_sum(mmd_pkg::ACC_W'($signed(sum_re_reg[c]))
                           + mmd_pkg::ACC_W'(mix_re_reg[c]));
            sat_im = sat_sum(mmd_pkg::ACC_W'($signed(sum_im_reg[c]))
                           + mmd_pkg::ACC_W'(mix_im_reg[c]));
            snap_re_next[c] = sat_re;
            snap_im_next[c] = sat_im;
            sum_re_next[c]  = dump_now ? '0 : sat_re;
            sum_im_next[c]  = dump_now ? '0 : sat_im;
        end
        dcnt_next = dump_now ? '0 : dcnt_reg + 1'b1;

        snap_valid_next = snap_valid_reg;
        if (adv && v3_reg && dump_now) begin
            snap_valid_next = 1'b1;
        end else if (load_e) begin
            snap_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CH; c++) begin
                sum_re_reg[c] <= '0;
                sum_im_reg[c] <= '0;
            end
            dcnt_reg <= '0;
        end else if (adv && v3_reg) begin
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v3_reg && dump_now) begin
            snap_re_reg <= snap_re_next;
            snap_im_reg <= snap_im_next;
        end
    end

    // Output buffer: loaded from the snapshot, shifted one channel per item taken.
    always_comb begin
        busy_next    = busy_reg;
        out_cnt_next = out_cnt_reg;
        buf_re_next  = buf_re_reg;
        buf_im_next  = buf_im_reg;
        if (load_e) begin
            busy_next    = 1'b1;
            out_cnt_next = '0;
            for (int c = 0; c < CH; c++) begin
                buf_re_next[c] = dump_div(snap_re_reg[c]);
                buf_im_next[c] = dump_div(snap_im_reg[c]);
            end
        end else if (m_accept) begin
            if (last_now) begin
                busy_next = 1'b0;
            end else begin
                out_cnt_next = out_cnt_reg + 1'b1;
                for (int c = 0; c < CH - 1; c++) begin
                    buf_re_next[c] = buf_re_reg[c + 1];
                    buf_im_next[c] = buf_im_reg[c + 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        buf_re_reg <= buf_re_next;
        buf_im_reg <= buf_im_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            snap_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
            out_cnt_reg    <= '0;
        end else begin
            if (adv) begin
                v1_reg <= s_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
            snap_valid_reg <= snap_valid_next;
            busy_reg       <= busy_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

endmodule

[design/mmd_checker.sv]
`timescale 1ns / 1ps

module mmd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [mmd_pkg::CH_IDX_W-1:0]        m_channel_index,
    input logic signed [mmd_pkg::SAMPLE_W-1:0] m_out_real,
    input logic signed [mmd_pkg::SAMPLE_W-1:0] m_out_imag,
    input logic                                m_last_channel
);

    // A stalled result holds its payload.
    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_channel_index)
            && $stable(m_out_real) && $stable(m_out_imag))
        else $error("result changed while stalled");

    // Within one decimation instant the channels follow each other without a gap.
    a_next_channel : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_channel |=>
            m_valid && (m_channel_index == $past(m_channel_index) + 3'd1))
        else $error("channel sequence broken");

    // The marker sits on the final channel and nowhere else.
    a_last_marker : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_channel ==
            (m_channel_index == mmd_pkg::CH_IDX_W'(mmd_pkg::CHANNEL_COUNT - 1))))
        else $error("last marker misplaced");

    // After the final channel, the next result starts again at channel zero.
    a_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_channel |=> !m_valid || (m_channel_index == '0))
        else $error("new block does not start at channel zero");

    a_reset_idle : assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind multichannel_mix_decimate mmd_checker u_mmd_checker (.*);

[tb/sv/multichannel_mix_decimate_tb.sv]
`timescale 1ns / 1ps

module multichannel_mix_decimate_tb;

    localparam int SINE_N      = 1 << mmd_pkg::SINE_TABLE_BITS;
    localparam int STEP_REGS   = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX  = 10;

    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

    localparam logic [2:0] REG_STEP_CH0 = 3'd0;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0]         chan;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } chan_result_t;

    class ddc_scoreboard;
        int           sine_tab [SINE_N];
        logic [31:0]  step [STEP_REGS];
        logic [31:0]  phase [STEP_REGS];
        longint       acc_re [STEP_REGS];
        longint       acc_im [STEP_REGS];
        int           taken;
        chan_result_t decimated_q [$];
        int           mismatches;
        int           n_samples;
        int           n_results;

        function new();
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] acc;
            logic [63:0] v;
            for (int k = 0; k < SINE_N; k++) begin
                x    = (QUARTER_TURN_Q30 * 64'(2 * k + 1)) >> (mmd_pkg::SINE_TABLE_BITS + 1);
                x2   = (x * x) >> 30;
                term = x;
                acc  = x;
                for (int n = 1; n <= 13; n += 2) begin
                    term = (term * x2) >> 30;
                    term = term / 64'((n + 1) * (n + 2));
                    if ((((n + 1) / 2) % 2) != 0) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
                v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
                if (v > 64'd32767) begin
                    v = 64'd32767;
                end
                sine_tab[k] = int'(v);
            end
            for (int c = 0; c < STEP_REGS; c++) begin
                step[c]   = '0;
                phase[c]  = '0;
                acc_re[c] = 0;
                acc_im[c] = 0;
            end
            taken      = 0;
            mismatches = 0;
            n_samples  = 0;
            n_results  = 0;
        endfunction

        function void set_step(int idx, logic [31:0] value);
            if (idx < STEP_REGS) begin
                step[idx] = value;
            end
        endfunction

        function int sine_at(logic [31:0] p);
            logic [1:0] quad;
            int         idx;
            quad = p[31:30];
            idx  = int'((p >> (30 - mmd_pkg::SINE_TABLE_BITS)) & (SINE_N - 1));
            if (quad[0]) begin
                idx = SINE_N - 1 - idx;
            end
            return quad[1] ? -sine_tab[idx] : sine_tab[idx];
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v > hi) begin
                return hi;
            end
            if (v < lo) begin
                return lo;
            end
            return v;
        endfunction

        function longint dump(longint s);
            longint q;
            q = s / mmd_pkg::DECIMATION;
            if ((s % mmd_pkg::DECIMATION) != 0 && s < 0) begin
                q = q - 1;
            end
            return clamp(q, -32768, 32767);
        endfunction

        function void mix_sample(logic signed [15:0] xr, logic signed [15:0] xi);
            longint       x;
            longint       y;
            longint       sn;
            longint       cs;
            longint       re;
            longint       im;
            longint       sum_hi;
            longint       sum_lo;
            chan_result_t res;
            x      = xr;
            y      = xi;
            sum_hi = (64'sd1 <<< (mmd_pkg::SUM_W - 1)) - 1;
            sum_lo = -(64'sd1 <<< (mmd_pkg::SUM_W - 1));
            n_samples++;
            for (int c = 0; c < mmd_pkg::CHANNEL_COUNT; c++) begin
                sn        = sine_at(phase[c]);
                cs        = sine_at(phase[c] + 32'h4000_0000);
                re        = (x * cs - y * sn + 64'sd16384) >>> 15;
                im        = (x * sn + y * cs + 64'sd16384) >>> 15;
                acc_re[c] = clamp(acc_re[c] + re, sum_lo, sum_hi);
                acc_im[c] = clamp(acc_im[c] + im, sum_lo, sum_hi);
                phase[c]  = phase[c] + step[c];
            end
            taken++;
            if (taken < mmd_pkg::DECIMATION) begin
                return;
            end
            taken = 0;
            for (int c = 0; c < mmd_pkg::CHANNEL_COUNT; c++) begin
                res.chan  = 3'(c);
                res.re    = 16'(dump(acc_re[c]));
                res.im    = 16'(dump(acc_im[c]));
                res.last  = (c == mmd_pkg::CHANNEL_COUNT - 1);
                acc_re[c] = 0;
                acc_im[c] = 0;
                decimated_q.push_back(res);
            end
        endfunction

        function void check_channel(chan_result_t got);
            chan_result_t want;
            n_results++;
            if (decimated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected result: ch %0d re %0d im %0d last %0d",
                             got.chan, got.re, got.im, got.last);
                end
                return;
            end
            want = decimated_q.pop_front();
            if (got.chan !== want.chan || got.re !== want.re || got.im !== want.im ||
                    got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Result mismatch: expected ch %0d re %0d im %0d last %0d,",
                             want.chan, want.re, want.im, want.last);
                    $display("    got ch %0d re %0d im %0d last %0d",
                             got.chan, got.re, got.im, got.last);
                end
            end
        endfunction

        function int pending();
            return decimated_q.size();
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn;
    logic                                cfg_write_en;
    logic [mmd_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [mmd_pkg::PHASE_W-1:0]         cfg_write_data;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [mmd_pkg::SAMPLE_W-1:0] s_in_real;
    logic signed [mmd_pkg::SAMPLE_W-1:0] s_in_imag;
    logic                                m_valid;
    logic                                m_ready;
    logic [mmd_pkg::CH_IDX_W-1:0]        m_channel_index;
    logic signed [mmd_pkg::SAMPLE_W-1:0] m_out_real;
    logic signed [mmd_pkg::SAMPLE_W-1:0] m_out_imag;
    logic                                m_last_channel;

    ddc_scoreboard sb;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          hold_req = 1'b0;
    logic          hold_seen = 1'b0;
    int            hold_left = 0;
    int            cycle_count = 0;

    multichannel_mix_decimate dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_write_data  (cfg_write_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_real       (s_in_real),
        .s_in_imag       (s_in_imag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_out_real      (m_out_real),
        .m_out_imag      (m_out_imag),
        .m_last_channel  (m_last_channel)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // A change of hold_req starts one long receiver hold.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.mix_sample(s_in_real, s_in_imag);
            end
            if (m_valid && m_ready) begin
                sb.check_channel(chan_result_t'{m_channel_index, m_out_real, m_out_imag,
                                                m_last_channel});
            end
        end
    end

    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] r;
        case ($urandom_range(7))
            0: r = 16'sh7FFF;
            1: r = 16'sh8000;
            2: r = 16'($urandom_range(15)) - 16'sd8;
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_step();
        logic [31:0] r;
        case ($urandom_range(5))
            0: r = 32'h0000_0000;
            1: r = 32'hFFFF_FFFF;
            2: r = 32'h8000_0000;
            default: r = $urandom;
        endcase
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_write_en   <= 1'b1;
        cfg_index      <= idx;
        cfg_write_data <= value;
        sb.set_step(int'(idx), value);
        @(posedge aclk);
    endtask

    task automatic program_steps(input logic [31:0] steps [STEP_REGS], input bit spares);
        for (int c = 0; c < STEP_REGS; c++) begin
            write_reg(REG_STEP_CH0 + 3'(c), steps[c]);
        end
        if (spares) begin
            for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
                write_reg(3'(i), $urandom | 32'h1);
            end
        end
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im);
        s_valid   <= 1'b1;
        s_in_real <= re;
        s_in_imag <= im;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid   <= 1'b0;
            s_in_real <= 16'($urandom);
            s_in_imag <= 16'($urandom);
            @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        while (sb.pending() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic run_burst(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            send_sample(pick_sample(), pick_sample());
        end
        s_valid <= 1'b0;
        wait_drain();
    endtask

    task automatic run_directed();
        int dir_re [20] = '{32767, 32767, 32767, -32768, 0, 32767, 32767, 32767,
                            0, 1, -1, -32768, 32767, -32768, 0, -1,
                            -32768, 32767, 0, 1};
        int dir_im [20] = '{-32768, -32768, -32768, -32768, 32767, 32767, 0, -32768,
                            0, -1, 1, -32768, 32767, 32767, -32768, -1,
                            0, 0, 32767, 1};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 20; i++) begin
            send_sample(16'(dir_re[i]), 16'(dir_im[i]));
        end
        s_valid <= 1'b0;
        wait_drain();
    endtask

    initial begin
        logic [31:0] steps [STEP_REGS];
        sb             = new();
        aresetn        = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = '0;
        cfg_write_data = '0;
        s_valid        = 1'b0;
        s_in_real      = '0;
        s_in_imag      = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full-scale samples at the start drive the sums into output saturation.
        steps = '{32'h0000_0000, 32'h2000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h4000_0000};
        program_steps(steps, 1'b1);
        run_directed();

        for (int c = 0; c < STEP_REGS; c++) begin
            steps[c] = pick_step();
        end
        program_steps(steps, 1'b0);
        run_burst(20, 58, 0);

        steps = '{default: 32'hFFFF_FFFF};
        program_steps(steps, 1'b0);
        run_burst(20, 0, 58);

        steps = '{default: 32'h0000_0000};
        program_steps(steps, 1'b1);
        run_burst(20, 7, 7);

        steps = '{32'h8000_0000, 32'h0000_0001, $urandom, $urandom, 32'h7FFF_FFFF};
        program_steps(steps, 1'b0);
        hold_req = ~hold_req;
        run_burst(24, 0, 0);

        for (int c = 0; c < STEP_REGS; c++) begin
            steps[c] = $urandom;
        end
        program_steps(steps, 1'b0);
        run_burst(16, 0, 0);

        if (sb.pending() != 0) begin
            sb.mismatches++;
        end
        $display("Run covered %0d samples and %0d channel results under six step settings,",
                 sb.n_samples, sb.n_results);
        $display("with full-scale saturation, spare register writes, gaps and back-pressure.");
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
